[rtl/srh_pkg.sv]
// shared constants, payload types and helper functions of the segment/rectangle edge hit block
`default_nettype none

package srh_pkg;

    localparam int COORD_BITS = 16;
    localparam int DIM_BITS = 15;
    // corner coordinates: left plus width, or top plus height, at full width
    localparam int EXT_BITS = ((COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS + 1) + 1;
    localparam int SEG_BITS = COORD_BITS + 1;
    localparam int REL_BITS = EXT_BITS + 1;
    localparam int PROD_BITS = SEG_BITS + REL_BITS;
    localparam int CROSS_BITS = PROD_BITS + 1;
    localparam int IN_BITS = 6 * COORD_BITS + 2 * DIM_BITS;
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_BITS = 8;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] ax;
        logic signed [COORD_BITS-1:0] ay;
        logic signed [COORD_BITS-1:0] bx;
        logic signed [COORD_BITS-1:0] by;
        logic signed [COORD_BITS-1:0] left;
        logic signed [COORD_BITS-1:0] top;
        logic [DIM_BITS-1:0]          w;
        logic [DIM_BITS-1:0]          h;
    } query_t;

    // position of one segment endpoint against the rectangle's edge lines
    typedef struct packed {
        logic lt_l;
        logic eq_l;
        logic lt_r;
        logic eq_r;
        logic lt_t;
        logic eq_t;
        logic lt_b;
        logic eq_b;
    } pt_flags_t;

    // sign of a cross product: positive is both bits low
    typedef struct packed {
        logic neg;
        logic zero;
    } orient_t;

    typedef struct packed {
        pt_flags_t fa;
        pt_flags_t fb;
        logic      w_nz;
        logic      h_nz;
    } side_t;

    typedef struct packed {
        logic signed [SEG_BITS-1:0] dx;
        logic signed [SEG_BITS-1:0] dy;
        logic signed [REL_BITS-1:0] relx_l;
        logic signed [REL_BITS-1:0] relx_r;
        logic signed [REL_BITS-1:0] rely_t;
        logic signed [REL_BITS-1:0] rely_b;
        side_t                      side;
    } prep_t;

    typedef struct packed {
        orient_t tl;
        orient_t tr;
        orient_t bl;
        orient_t br;
        side_t   side;
    } orient_set_t;

    // orientation of an endpoint against an axis-aligned edge; flip for vertical edges
    function automatic orient_t edge_orient(input logic nz, input logic lt, input logic eq,
                                            input logic flip);
        orient_t o;
        o.zero = !nz || eq;
        o.neg = nz && !eq && (flip ? !lt : lt);
        return o;
    endfunction

    // edge line lies between the two endpoints' coordinates, inclusive
    function automatic logic in_span(input logic a_lt, input logic a_eq,
                                     input logic b_lt, input logic b_eq);
        logic a_gt;
        logic b_gt;
        a_gt = !a_lt && !a_eq;
        b_gt = !b_lt && !b_eq;
        return !(a_lt && b_lt) && !(a_gt && b_gt);
    endfunction

endpackage

`default_nettype wire

[rtl/srh_prep.sv]
// two front stages: corner sums, segment and corner deltas, endpoint position flags
`default_nettype none

module srh_prep (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  srh_pkg::query_t in_query,
    output logic            out_valid,
    input  logic            out_ready,
    output srh_pkg::prep_t  out_prep
);

    logic                                  v1_reg;
    logic                                  v2_reg;
    logic                                  rdy1;
    logic                                  rdy2;
    logic signed [srh_pkg::COORD_BITS-1:0] ax_reg;
    logic signed [srh_pkg::COORD_BITS-1:0] ay_reg;
    logic signed [srh_pkg::COORD_BITS-1:0] bx_reg;
    logic signed [srh_pkg::COORD_BITS-1:0] by_reg;
    logic signed [srh_pkg::EXT_BITS-1:0]   left_reg;
    logic signed [srh_pkg::EXT_BITS-1:0]   top_reg;
    logic signed [srh_pkg::EXT_BITS-1:0]   right_reg;
    logic signed [srh_pkg::EXT_BITS-1:0]   bottom_reg;
    logic signed [srh_pkg::SEG_BITS-1:0]   dx_reg;
    logic signed [srh_pkg::SEG_BITS-1:0]   dy_reg;
    logic                                  w_nz_reg;
    logic                                  h_nz_reg;
    logic signed [srh_pkg::EXT_BITS-1:0]   left_next;
    logic signed [srh_pkg::EXT_BITS-1:0]   top_next;
    logic signed [srh_pkg::EXT_BITS-1:0]   right_next;
    logic signed [srh_pkg::EXT_BITS-1:0]   bottom_next;
    srh_pkg::prep_t                        prep_reg;
    srh_pkg::prep_t                        prep_next;

    function automatic srh_pkg::pt_flags_t pt_flags(
        input logic signed [srh_pkg::EXT_BITS-1:0] px,
        input logic signed [srh_pkg::EXT_BITS-1:0] py,
        input logic signed [srh_pkg::EXT_BITS-1:0] l,
        input logic signed [srh_pkg::EXT_BITS-1:0] r,
        input logic signed [srh_pkg::EXT_BITS-1:0] t,
        input logic signed [srh_pkg::EXT_BITS-1:0] b
    );
        srh_pkg::pt_flags_t f;
        f.lt_l = px < l;
        f.eq_l = px == l;
        f.lt_r = px < r;
        f.eq_r = px == r;
        f.lt_t = py < t;
        f.eq_t = py == t;
        f.lt_b = py < b;
        f.eq_b = py == b;
        return f;
    endfunction

    assign rdy2 = !v2_reg || out_ready;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v2_reg;
    assign out_prep = prep_reg;

    always_comb
    begin
        left_next = srh_pkg::EXT_BITS'(in_query.left);
        top_next = srh_pkg::EXT_BITS'(in_query.top);
        right_next = left_next + srh_pkg::EXT_BITS'($signed({1'b0, in_query.w}));
        bottom_next = top_next + srh_pkg::EXT_BITS'($signed({1'b0, in_query.h}));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            ax_reg <= in_query.ax;
            ay_reg <= in_query.ay;
            bx_reg <= in_query.bx;
            by_reg <= in_query.by;
            left_reg <= left_next;
            top_reg <= top_next;
            right_reg <= right_next;
            bottom_reg <= bottom_next;
            dx_reg <= srh_pkg::SEG_BITS'(in_query.bx) - srh_pkg::SEG_BITS'(in_query.ax);
            dy_reg <= srh_pkg::SEG_BITS'(in_query.by) - srh_pkg::SEG_BITS'(in_query.ay);
            w_nz_reg <= in_query.w != '0;
            h_nz_reg <= in_query.h != '0;
        end
    end

    always_comb
    begin
        prep_next.dx = dx_reg;
        prep_next.dy = dy_reg;
        prep_next.relx_l = srh_pkg::REL_BITS'(left_reg) - srh_pkg::REL_BITS'(ax_reg);
        prep_next.relx_r = srh_pkg::REL_BITS'(right_reg) - srh_pkg::REL_BITS'(ax_reg);
        prep_next.rely_t = srh_pkg::REL_BITS'(top_reg) - srh_pkg::REL_BITS'(ay_reg);
        prep_next.rely_b = srh_pkg::REL_BITS'(bottom_reg) - srh_pkg::REL_BITS'(ay_reg);
        prep_next.side.fa = pt_flags(srh_pkg::EXT_BITS'(ax_reg), srh_pkg::EXT_BITS'(ay_reg),
                                     left_reg, right_reg, top_reg, bottom_reg);
        prep_next.side.fb = pt_flags(srh_pkg::EXT_BITS'(bx_reg), srh_pkg::EXT_BITS'(by_reg),
                                     left_reg, right_reg, top_reg, bottom_reg);
        prep_next.side.w_nz = w_nz_reg;
        prep_next.side.h_nz = h_nz_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && rdy2)
        begin
            prep_reg <= prep_next;
        end
    end

endmodule

`default_nettype wire

[rtl/srh_cross.sv]
// two cross-product stages: registered products, then difference and sign per corner
`default_nettype none

module srh_cross (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  srh_pkg::prep_t       in_prep,
    output logic                 out_valid,
    input  logic                 out_ready,
    output srh_pkg::orient_set_t out_orient
);

    logic                                  v1_reg;
    logic                                  v2_reg;
    logic                                  rdy1;
    logic                                  rdy2;
    logic signed [srh_pkg::PROD_BITS-1:0]  p_dx_t_reg;
    logic signed [srh_pkg::PROD_BITS-1:0]  p_dx_b_reg;
    logic signed [srh_pkg::PROD_BITS-1:0]  p_dy_l_reg;
    logic signed [srh_pkg::PROD_BITS-1:0]  p_dy_r_reg;
    srh_pkg::side_t                        side_reg;
    logic signed [srh_pkg::CROSS_BITS-1:0] cross_tl;
    logic signed [srh_pkg::CROSS_BITS-1:0] cross_tr;
    logic signed [srh_pkg::CROSS_BITS-1:0] cross_bl;
    logic signed [srh_pkg::CROSS_BITS-1:0] cross_br;
    srh_pkg::orient_set_t                  orient_reg;
    srh_pkg::orient_set_t                  orient_next;

    function automatic srh_pkg::orient_t sign_of(
        input logic signed [srh_pkg::CROSS_BITS-1:0] v
    );
        srh_pkg::orient_t o;
        o.neg = v[srh_pkg::CROSS_BITS-1];
        o.zero = v == '0;
        return o;
    endfunction

    assign rdy2 = !v2_reg || out_ready;
    assign rdy1 = !v1_reg || rdy2;
    assign in_ready = rdy1;
    assign out_valid = v2_reg;
    assign out_orient = orient_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
            begin
                v1_reg <= in_valid;
            end
            if (rdy2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy1)
        begin
            p_dx_t_reg <= srh_pkg::PROD_BITS'(in_prep.dx) * srh_pkg::PROD_BITS'(in_prep.rely_t);
            p_dx_b_reg <= srh_pkg::PROD_BITS'(in_prep.dx) * srh_pkg::PROD_BITS'(in_prep.rely_b);
            p_dy_l_reg <= srh_pkg::PROD_BITS'(in_prep.dy) * srh_pkg::PROD_BITS'(in_prep.relx_l);
            p_dy_r_reg <= srh_pkg::PROD_BITS'(in_prep.dy) * srh_pkg::PROD_BITS'(in_prep.relx_r);
            side_reg <= in_prep.side;
        end
    end

    // corner orientation against the segment: dx*(cy-ay) - dy*(cx-ax)
    always_comb
    begin
        cross_tl = srh_pkg::CROSS_BITS'(p_dx_t_reg) - srh_pkg::CROSS_BITS'(p_dy_l_reg);
        cross_tr = srh_pkg::CROSS_BITS'(p_dx_t_reg) - srh_pkg::CROSS_BITS'(p_dy_r_reg);
        cross_bl = srh_pkg::CROSS_BITS'(p_dx_b_reg) - srh_pkg::CROSS_BITS'(p_dy_l_reg);
        cross_br = srh_pkg::CROSS_BITS'(p_dx_b_reg) - srh_pkg::CROSS_BITS'(p_dy_r_reg);
        orient_next.tl = sign_of(cross_tl);
        orient_next.tr = sign_of(cross_tr);
        orient_next.bl = sign_of(cross_bl);
        orient_next.br = sign_of(cross_br);
        orient_next.side = side_reg;
    end

    always_ff @(posedge clk)
    begin
        if (v1_reg && rdy2)
        begin
            orient_reg <= orient_next;
        end
    end

endmodule

`default_nettype wire

[rtl/srh_decide.sv]
// final stage: per-edge touch decision and the registered hit result
`default_nettype none

module srh_decide (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  srh_pkg::orient_set_t in_orient,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 hit
);

    logic               v_reg;
    logic               rdy;
    logic               hit_reg;
    logic               hit_next;
    srh_pkg::pt_flags_t fa;
    srh_pkg::pt_flags_t fb;
    logic               w_nz;
    logic               h_nz;
    logic               cx_l;
    logic               cx_r;
    logic               cy_t;
    logic               cy_b;
    logic               ax_in;
    logic               bx_in;
    logic               ay_in;
    logic               by_in;
    logic               hit_top;
    logic               hit_bottom;
    logic               hit_left;
    logic               hit_right;

    function automatic logic seg_touch(
        input srh_pkg::orient_t o1,
        input srh_pkg::orient_t o2,
        input srh_pkg::orient_t o3,
        input srh_pkg::orient_t o4,
        input logic             in3,
        input logic             in4,
        input logic             a_on,
        input logic             b_on
    );
        return ((o1 != o2) && (o3 != o4)) || (o1.zero && in3) || (o2.zero && in4) ||
               (o3.zero && a_on) || (o4.zero && b_on);
    endfunction

    assign rdy = !v_reg || out_ready;
    assign in_ready = rdy;
    assign out_valid = v_reg;
    assign hit = hit_reg;

    always_comb
    begin
        fa = in_orient.side.fa;
        fb = in_orient.side.fb;
        w_nz = in_orient.side.w_nz;
        h_nz = in_orient.side.h_nz;
        // edge lines that fall inside the segment's bounding box
        cx_l = srh_pkg::in_span(fa.lt_l, fa.eq_l, fb.lt_l, fb.eq_l);
        cx_r = srh_pkg::in_span(fa.lt_r, fa.eq_r, fb.lt_r, fb.eq_r);
        cy_t = srh_pkg::in_span(fa.lt_t, fa.eq_t, fb.lt_t, fb.eq_t);
        cy_b = srh_pkg::in_span(fa.lt_b, fa.eq_b, fb.lt_b, fb.eq_b);
        // endpoints within the rectangle's x and y extents
        ax_in = !fa.lt_l && (fa.lt_r || fa.eq_r);
        bx_in = !fb.lt_l && (fb.lt_r || fb.eq_r);
        ay_in = !fa.lt_t && (fa.lt_b || fa.eq_b);
        by_in = !fb.lt_t && (fb.lt_b || fb.eq_b);
        hit_top = seg_touch(in_orient.tl, in_orient.tr,
                            srh_pkg::edge_orient(w_nz, fa.lt_t, fa.eq_t, 1'b0),
                            srh_pkg::edge_orient(w_nz, fb.lt_t, fb.eq_t, 1'b0),
                            cx_l && cy_t, cx_r && cy_t,
                            ax_in && fa.eq_t, bx_in && fb.eq_t);
        hit_bottom = seg_touch(in_orient.bl, in_orient.br,
                               srh_pkg::edge_orient(w_nz, fa.lt_b, fa.eq_b, 1'b0),
                               srh_pkg::edge_orient(w_nz, fb.lt_b, fb.eq_b, 1'b0),
                               cx_l && cy_b, cx_r && cy_b,
                               ax_in && fa.eq_b, bx_in && fb.eq_b);
        hit_left = seg_touch(in_orient.tl, in_orient.bl,
                             srh_pkg::edge_orient(h_nz, fa.lt_l, fa.eq_l, 1'b1),
                             srh_pkg::edge_orient(h_nz, fb.lt_l, fb.eq_l, 1'b1),
                             cx_l && cy_t, cx_l && cy_b,
                             ay_in && fa.eq_l, by_in && fb.eq_l);
        hit_right = seg_touch(in_orient.tr, in_orient.br,
                              srh_pkg::edge_orient(h_nz, fa.lt_r, fa.eq_r, 1'b1),
                              srh_pkg::edge_orient(h_nz, fb.lt_r, fb.eq_r, 1'b1),
                              cx_r && cy_t, cx_r && cy_b,
                              ay_in && fa.eq_r, by_in && fb.eq_r);
        hit_next = hit_top || hit_bottom || hit_left || hit_right;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (rdy)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && rdy)
        begin
            hit_reg <= hit_next;
        end
    end

endmodule

`default_nettype wire

[rtl/segment_rect_edge_hit.sv]
// an accepted input transaction reaches the master side through the register stages in
// order: corner sums, deltas and flags, products, cross signs, edge decision
// throughput: one transaction per cycle while m_tready is high; a stage refills in the
// cycle it hands its item on, holds it while the next one is full; stalls back up without loss
// reset clears only the stage valid bits, the pipeline comes up empty
`default_nettype none

module segment_rect_edge_hit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // start_x, start_y, end_x, end_y, box_left, box_top, box_width, box_height, zero pad
    input  logic [srh_pkg::IN_TDATA_BITS-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // hit, zero pad
    output logic [srh_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);

    localparam int CB = srh_pkg::COORD_BITS;
    localparam int DB = srh_pkg::DIM_BITS;

    srh_pkg::query_t      query;
    srh_pkg::prep_t       prep;
    srh_pkg::orient_set_t orient;
    logic                 prep_valid;
    logic                 prep_ready;
    logic                 orient_valid;
    logic                 orient_ready;
    logic                 hit;

    always_comb
    begin
        query.ax = s_tdata[0*CB +: CB];
        query.ay = s_tdata[1*CB +: CB];
        query.bx = s_tdata[2*CB +: CB];
        query.by = s_tdata[3*CB +: CB];
        query.left = s_tdata[4*CB +: CB];
        query.top = s_tdata[5*CB +: CB];
        query.w = s_tdata[6*CB +: DB];
        query.h = s_tdata[6*CB+DB +: DB];
    end

    srh_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_query  (query),
        .out_valid (prep_valid),
        .out_ready (prep_ready),
        .out_prep  (prep)
    );

    srh_cross u_cross (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (prep_valid),
        .in_ready   (prep_ready),
        .in_prep    (prep),
        .out_valid  (orient_valid),
        .out_ready  (orient_ready),
        .out_orient (orient)
    );

    srh_decide u_decide (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (orient_valid),
        .in_ready  (orient_ready),
        .in_orient (orient),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .hit       (hit)
    );

    assign m_tdata = {{(srh_pkg::OUT_TDATA_BITS-1){1'b0}}, hit};

endmodule

`default_nettype wire

[tb/tb_top.sv]
// testbench for segment_rect_edge_hit: directed and random queries against an edge-hit predictor
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_HALF = 10;
    localparam int RESET_CYCLES = 6;
    localparam int RANDOM_QUERIES = 550;
    localparam int HOLD_CYCLES = 80;
    localparam int DRAIN_CYCLES = 12;
    localparam int STUCK_LIMIT = 1000;
    localparam int STEADY_FROM = 250;
    localparam int STEADY_TO = 310;

    // expected outcome of a directed row
    localparam logic [1:0] HIT_NO = 2'd0;
    localparam logic [1:0] HIT_YES = 2'd1;
    localparam logic [1:0] HIT_MODEL = 2'd2;

    typedef struct packed {
        srh_pkg::query_t q;
        logic [1:0]      want;
    } row_t;

    typedef struct packed {
        logic [31:0] id;
        logic        hit;
    } pending_t;

    logic                                clk = 1'b0;
    logic                                rst_n = 1'b0;
    logic                                s_tvalid = 1'b0;
    logic                                s_tready;
    logic [srh_pkg::IN_TDATA_BITS-1:0]   s_tdata = '0;
    logic                                m_tvalid;
    logic                                m_tready = 1'b0;
    logic [srh_pkg::OUT_TDATA_BITS-1:0]  m_tdata;

    row_t     directed_rows[$];
    pending_t expected_hits[$];
    int       queries_sent = 0;
    int       results_seen = 0;
    int       hits_seen = 0;
    int       error_count = 0;
    int       holds_done = 0;
    int       ready_hold = 0;
    int       stuck_cycles = 0;
    bit       steady = 1'b0;

    segment_rect_edge_hit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #CLK_HALF clk = ~clk;

    // sign of (b - a) x (c - a)
    function automatic int cross_sign(input longint ax, input longint ay, input longint bx,
                                      input longint by, input longint cx, input longint cy);
        longint v;
        v = (bx - ax) * (cy - ay) - (by - ay) * (cx - ax);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    // c inside the bounding box of a and b
    function automatic bit in_bbox(input longint ax, input longint ay, input longint bx,
                                   input longint by, input longint cx, input longint cy);
        return cx >= ((ax < bx) ? ax : bx) && cx <= ((ax < bx) ? bx : ax) &&
               cy >= ((ay < by) ? ay : by) && cy <= ((ay < by) ? by : ay);
    endfunction

    function automatic bit segments_touch(input longint p1x, input longint p1y,
                                          input longint p2x, input longint p2y,
                                          input longint p3x, input longint p3y,
                                          input longint p4x, input longint p4y);
        int o1;
        int o2;
        int o3;
        int o4;
        o1 = cross_sign(p1x, p1y, p2x, p2y, p3x, p3y);
        o2 = cross_sign(p1x, p1y, p2x, p2y, p4x, p4y);
        o3 = cross_sign(p3x, p3y, p4x, p4y, p1x, p1y);
        o4 = cross_sign(p3x, p3y, p4x, p4y, p2x, p2y);
        if (o1 != o2 && o3 != o4)
            return 1'b1;
        return (o1 == 0 && in_bbox(p1x, p1y, p2x, p2y, p3x, p3y)) ||
               (o2 == 0 && in_bbox(p1x, p1y, p2x, p2y, p4x, p4y)) ||
               (o3 == 0 && in_bbox(p3x, p3y, p4x, p4y, p1x, p1y)) ||
               (o4 == 0 && in_bbox(p3x, p3y, p4x, p4y, p2x, p2y));
    endfunction

    function automatic logic predict_hit(input srh_pkg::query_t q);
        longint ax;
        longint ay;
        longint bx;
        longint by;
        longint l;
        longint t;
        longint r;
        longint b;
        ax = $signed(q.ax);
        ay = $signed(q.ay);
        bx = $signed(q.bx);
        by = $signed(q.by);
        l = $signed(q.left);
        t = $signed(q.top);
        // corners at full width, no wrap
        r = l + longint'(q.w);
        b = t + longint'(q.h);
        return segments_touch(ax, ay, bx, by, l, t, r, t) ||
               segments_touch(ax, ay, bx, by, l, t, l, b) ||
               segments_touch(ax, ay, bx, by, r, t, r, b) ||
               segments_touch(ax, ay, bx, by, l, b, r, b);
    endfunction

    function automatic logic [srh_pkg::IN_TDATA_BITS-1:0] pack_query(
        input srh_pkg::query_t q
    );
        logic [srh_pkg::IN_TDATA_BITS-1:0] d;
        d = '0;
        d[srh_pkg::IN_BITS-1:0] = {q.h, q.w, q.top, q.left, q.by, q.bx, q.ay, q.ax};
        return d;
    endfunction

    function automatic logic signed [srh_pkg::COORD_BITS-1:0] clamp16(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[srh_pkg::COORD_BITS-1:0];
    endfunction

    function automatic void add_row(input int ax, input int ay, input int bx, input int by,
                                    input int l, input int t, input int w, input int h,
                                    input logic [1:0] want);
        row_t row;
        row.q.ax = clamp16(ax);
        row.q.ay = clamp16(ay);
        row.q.bx = clamp16(bx);
        row.q.by = clamp16(by);
        row.q.left = clamp16(l);
        row.q.top = clamp16(t);
        row.q.w = w[srh_pkg::DIM_BITS-1:0];
        row.q.h = h[srh_pkg::DIM_BITS-1:0];
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    function automatic int pick_dim();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 0;
        if (r < 70)
            return $urandom_range(1, 40);
        return $urandom_range(0, 32767);
    endfunction

    // offset that lands a little outside, on, or inside an extent
    function automatic int near_off(input int extent);
        return int'($urandom_range(0, extent + 40)) - 20;
    endfunction

    function automatic void point_on_side(input int l, input int t, input int w, input int h,
                                          output int x, output int y);
        case ($urandom_range(0, 3))
            0:
            begin
                x = l + $urandom_range(0, w);
                y = t;
            end
            1:
            begin
                x = l + $urandom_range(0, w);
                y = t + h;
            end
            2:
            begin
                x = l;
                y = t + $urandom_range(0, h);
            end
            default:
            begin
                x = l + w;
                y = t + $urandom_range(0, h);
            end
        endcase
    endfunction

    function automatic srh_pkg::query_t random_query();
        srh_pkg::query_t q;
        int l;
        int t;
        int w;
        int h;
        int x;
        int y;
        int kind;
        kind = $urandom_range(0, 9);
        l = int'($urandom_range(0, 65535)) - 32768;
        t = int'($urandom_range(0, 65535)) - 32768;
        w = pick_dim();
        h = pick_dim();
        if (kind == 7)
        begin
            case ($urandom_range(0, 2))
                0: w = 0;
                1: h = 0;
                default:
                begin
                    w = 0;
                    h = 0;
                end
            endcase
        end
        q.left = l[srh_pkg::COORD_BITS-1:0];
        q.top = t[srh_pkg::COORD_BITS-1:0];
        q.w = w[srh_pkg::DIM_BITS-1:0];
        q.h = h[srh_pkg::DIM_BITS-1:0];
        q.ax = clamp16(l + near_off(w));
        q.ay = clamp16(t + near_off(h));
        q.bx = clamp16(l + near_off(w));
        q.by = clamp16(t + near_off(h));
        case (kind)
            4:
            begin
                point_on_side(l, t, w, h, x, y);
                q.ax = clamp16(x);
                q.ay = clamp16(y);
            end
            5:
            begin
                // both ends on one edge line
                if ($urandom_range(0, 1))
                begin
                    q.ay = clamp16(($urandom_range(0, 1)) ? t : t + h);
                    q.by = q.ay;
                end
                else
                begin
                    q.ax = clamp16(($urandom_range(0, 1)) ? l : l + w);
                    q.bx = q.ax;
                end
            end
            6:
            begin
                if ($urandom_range(0, 1))
                begin
                    point_on_side(l, t, w, h, x, y);
                    q.ax = clamp16(x);
                    q.ay = clamp16(y);
                end
                q.bx = q.ax;
                q.by = q.ay;
            end
            8, 9:
            begin
                q.ax = srh_pkg::COORD_BITS'($urandom());
                q.ay = srh_pkg::COORD_BITS'($urandom());
                q.bx = srh_pkg::COORD_BITS'($urandom());
                q.by = srh_pkg::COORD_BITS'($urandom());
                q.w = srh_pkg::DIM_BITS'($urandom());
                q.h = srh_pkg::DIM_BITS'($urandom());
            end
            default: ;
        endcase
        return q;
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 25);
    endfunction

    task automatic send_query(input srh_pkg::query_t q, input logic hit);
        int gap;
        pending_t p;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tdata <= pack_query(q);
        s_tvalid <= 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        p.id = queries_sent;
        p.hit = hit;
        expected_hits.push_back(p);
        queries_sent++;
    endtask

    // receiver: random stalls plus two long hold-offs that back the pipeline up
    always @(posedge clk)
    begin : receiver
        int roll;
        roll = $urandom_range(0, 99);
        if (!rst_n)
            m_tready <= 1'b0;
        else if (ready_hold > 0)
        begin
            m_tready <= 1'b0;
            ready_hold <= ready_hold - 1;
        end
        else if (holds_done < 2 && queries_sent >= ((holds_done == 0) ? 150 : 420))
        begin
            m_tready <= 1'b0;
            ready_hold <= HOLD_CYCLES - 1;
            holds_done <= holds_done + 1;
        end
        else if (steady)
            m_tready <= 1'b1;
        else if (roll < 65)
            m_tready <= 1'b1;
        else if (roll < 93)
        begin
            m_tready <= 1'b0;
            ready_hold <= $urandom_range(0, 2);
        end
        else
        begin
            m_tready <= 1'b0;
            ready_hold <= $urandom_range(7, 24);
        end
    end

    always @(posedge clk)
    begin : check_results
        pending_t p;
        logic [srh_pkg::OUT_TDATA_BITS-1:0] want_word;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (m_tdata[0])
                hits_seen++;
            if (expected_hits.size() == 0)
            begin
                $display("%0t: unexpected result transaction, tdata %h", $time, m_tdata);
                error_count++;
            end
            else
            begin
                p = expected_hits.pop_front();
                want_word = '0;
                want_word[0] = p.hit;
                if (m_tdata !== want_word)
                begin
                    $display("%0t: query %0d hit mismatch, expected %h actual %h",
                             $time, p.id, want_word, m_tdata);
                    error_count++;
                end
            end
        end
    end

    // watchdog: no transaction on either side for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                stuck_cycles <= 0;
            else
                stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT)
            begin
                $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                         $time, stuck_cycles, expected_hits.size());
                $display("FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        int i;
        srh_pkg::query_t q;
        // crossings, inside, outside
        add_row(-5, 5, 5, 5, 0, 0, 10, 10, HIT_YES);
        add_row(2, 2, 8, 8, 0, 0, 10, 10, HIT_NO);
        add_row(20, 20, 30, 30, 0, 0, 10, 10, HIT_NO);
        // single-point segments
        add_row(0, 5, 0, 5, 0, 0, 10, 10, HIT_YES);
        add_row(5, 5, 5, 5, 0, 0, 10, 10, HIT_NO);
        add_row(10, 10, 10, 10, 0, 0, 10, 10, HIT_YES);
        // running along the top edge line
        add_row(-5, 0, 3, 0, 0, 0, 10, 10, HIT_YES);
        add_row(11, 0, 20, 0, 0, 0, 10, 10, HIT_NO);
        add_row(10, 0, 20, 0, 0, 0, 10, 10, HIT_YES);
        // flat and point rectangles
        add_row(-5, 5, 5, 5, 0, 0, 0, 10, HIT_YES);
        add_row(0, 0, 6, 6, 3, 3, 0, 0, HIT_YES);
        add_row(0, 0, 6, 7, 3, 3, 0, 0, HIT_NO);
        add_row(3, 3, 3, 3, 3, 3, 0, 0, HIT_YES);
        add_row(0, 0, 0, 0, 0, 0, 0, 0, HIT_YES);
        // coordinate extremes, then rows whose expected hit comes from the predictor
        add_row(-32768, -32768, 32767, 32767, -32768, -32768, 32767, 32767, HIT_YES);
        add_row(-32768, 32767, 32767, 32767, 32767, 32767, 32767, 32767, HIT_YES);
        add_row(-2, 0, -2, 10, 32767, 0, 32767, 10, HIT_NO);
        add_row(32767, -32768, 32767, 32767, 0, 0, 5, 5, HIT_NO);
        add_row(-32768, 32767, 32767, -32768, -100, -100, 200, 200, HIT_YES);
        add_row(-32768, -32768, -32768, -32768, -32768, -32768, 0, 0, HIT_YES);
        add_row(0, 11, 11, 0, 0, 0, 10, 10, HIT_MODEL);
        add_row(11, 10, 20, 20, 0, 0, 10, 10, HIT_MODEL);
        add_row(32767, 32767, -32768, -32768, 0, 0, 32767, 32767, HIT_MODEL);

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[k])
            send_query(directed_rows[k].q, (directed_rows[k].want == HIT_MODEL) ?
                       predict_hit(directed_rows[k].q) : directed_rows[k].want[0]);

        for (i = 0; i < RANDOM_QUERIES; i++)
        begin
            // a stretch where neither side idles
            steady = (i >= STEADY_FROM && i < STEADY_TO);
            q = random_query();
            send_query(q, predict_hit(q));
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        while (expected_hits.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("%0d queries (%0d directed), %0d results, %0d hits, %0d long output holds",
                 queries_sent, directed_rows.size(), results_seen, hits_seen, holds_done);
        $display("coverage: crossings, edge-line overlaps, point segments, flat boxes, extremes");
        if (error_count == 0 && expected_hits.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
